// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk_i, suspended while rst_ni is low.
`define MMC3_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge of clk_i, reset included.
`define MMC3_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/mmc3_pkg.sv
// Types, codes and constants shared by the bank mapper modules.
`default_nettype none

package mmc3_pkg;

  localparam int unsigned PrgMaskW = 6;
  localparam int unsigned ChrMaskW = 8;
  localparam int unsigned MapAddrW = 19;

  // Item kinds.
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // Result regions.
  localparam logic [2:0] REGION_CHR  = 3'd0;
  localparam logic [2:0] REGION_NT   = 3'd1;
  localparam logic [2:0] REGION_WRAM = 3'd2;
  localparam logic [2:0] REGION_PRG  = 3'd3;
  localparam logic [2:0] REGION_NONE = 3'd4;

  // Mirroring codes.
  localparam logic [1:0] MIRROR_VERTICAL   = 2'd0;
  localparam logic [1:0] MIRROR_HORIZONTAL = 2'd1;
  localparam logic [1:0] MIRROR_FOUR       = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_PRG_MASK    = 2'd0;
  localparam logic [1:0] CFG_CHR_MASK    = 2'd1;
  localparam logic [1:0] CFG_FOUR_SCREEN = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] address;
    logic [7:0]  write_data;
  } in_item_t;

  typedef struct packed {
    logic [2:0]          region;
    logic [MapAddrW-1:0] mapped_address;
    logic [1:0]          mirroring;
    logic                irq_fire;
  } out_item_t;

  // Bank state that the address mapping looks at.
  typedef struct packed {
    logic [PrgMaskW-1:0] prg_bank_mask;
    logic [ChrMaskW-1:0] chr_bank_mask;
    logic [7:0][7:0]     bank_numbers;
    logic                prg_mode;
    logic                chr_invert;
    logic                mapping_live;
  } map_state_t;

endpackage

`default_nettype wire

// File: rtl/mmc3_regs.sv
// Mapper register file, configuration registers and scanline IRQ counter.
`default_nettype none

module mmc3_regs (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [7:0]            cfg_data_i,
  input  mmc3_pkg::in_item_t    item_i,
  input  logic                  advance_i,
  output mmc3_pkg::map_state_t  state_o,
  output logic [1:0]            mirroring_o,
  output logic                  irq_fire_o
);
  import mmc3_pkg::*;

  // Register groups selected by address bits 14:13.
  localparam logic [1:0] SEL_BANK   = 2'd0;
  localparam logic [1:0] SEL_MIRROR = 2'd1;
  localparam logic [1:0] SEL_IRQ    = 2'd2;
  localparam logic [1:0] SEL_ENABLE = 2'd3;

  logic [PrgMaskW-1:0] prg_mask_q;
  logic [ChrMaskW-1:0] chr_mask_q;
  logic                four_screen_q;

  logic [2:0]      bank_index_q, bank_index_d;
  logic            prg_mode_q, prg_mode_d;
  logic            chr_invert_q, chr_invert_d;
  logic [7:0][7:0] bank_q, bank_d;
  logic            live_q, live_d;
  logic            horiz_q, horiz_d;
  logic [7:0]      latch_q, latch_d;
  logic [7:0]      count_q, count_d;
  logic            reload_q, reload_d;
  logic            irq_on_q, irq_on_d;

  logic       reg_write;
  logic       tick;
  logic       odd;
  logic       reload_now;
  logic [7:0] count_dec;

  assign reg_write  = (item_i.kind == KIND_WRITE) && item_i.address[15];
  assign tick       = (item_i.kind == KIND_TICK);
  assign odd        = item_i.address[0];
  assign reload_now = (count_q == 8'd0) || reload_q;
  assign count_dec  = count_q - 8'd1;

  always_comb begin
    bank_index_d = bank_index_q;
    prg_mode_d   = prg_mode_q;
    chr_invert_d = chr_invert_q;
    bank_d       = bank_q;
    live_d       = live_q;
    horiz_d      = horiz_q;
    latch_d      = latch_q;
    count_d      = count_q;
    reload_d     = reload_q;
    irq_on_d     = irq_on_q;
    if (reg_write) begin
      unique case (item_i.address[14:13])
        SEL_BANK: begin
          if (odd) begin
            bank_d[bank_index_q] = item_i.write_data;
            live_d               = 1'b1;
          end else begin
            bank_index_d = item_i.write_data[2:0];
            prg_mode_d   = item_i.write_data[6];
            chr_invert_d = item_i.write_data[7];
          end
        end
        SEL_MIRROR: begin
          if (!odd) begin
            horiz_d = item_i.write_data[0];
          end
        end
        SEL_IRQ: begin
          if (odd) begin
            count_d  = 8'd0;
            reload_d = 1'b1;
          end else begin
            latch_d = item_i.write_data;
          end
        end
        SEL_ENABLE: begin
          irq_on_d = odd;
        end
        default: begin
        end
      endcase
    end else if (tick) begin
      if (reload_now) begin
        count_d  = latch_q;
        reload_d = 1'b0;
      end else begin
        count_d = count_dec;
      end
    end
  end

  // The interrupt is raised when the counter decrements onto zero.
  assign irq_fire_o  = tick && !reload_now && (count_dec == 8'd0) && irq_on_q;
  assign mirroring_o = four_screen_q ? MIRROR_FOUR
                     : (horiz_d ? MIRROR_HORIZONTAL : MIRROR_VERTICAL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_mask_q    <= '1;
      chr_mask_q    <= '1;
      four_screen_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PRG_MASK:    prg_mask_q    <= cfg_data_i[PrgMaskW-1:0];
        CFG_CHR_MASK:    chr_mask_q    <= cfg_data_i;
        CFG_FOUR_SCREEN: four_screen_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_index_q <= '0;
      prg_mode_q   <= 1'b0;
      chr_invert_q <= 1'b0;
      bank_q       <= '0;
      live_q       <= 1'b0;
      horiz_q      <= 1'b0;
      latch_q      <= '0;
      count_q      <= '0;
      reload_q     <= 1'b0;
      irq_on_q     <= 1'b0;
    end else if (advance_i) begin
      bank_index_q <= bank_index_d;
      prg_mode_q   <= prg_mode_d;
      chr_invert_q <= chr_invert_d;
      bank_q       <= bank_d;
      live_q       <= live_d;
      horiz_q      <= horiz_d;
      latch_q      <= latch_d;
      count_q      <= count_d;
      reload_q     <= reload_d;
      irq_on_q     <= irq_on_d;
    end
  end

  assign state_o = '{prg_bank_mask: prg_mask_q,
                     chr_bank_mask: chr_mask_q,
                     bank_numbers:  bank_q,
                     prg_mode:      prg_mode_q,
                     chr_invert:    chr_invert_q,
                     mapping_live:  live_q};

endmodule

`default_nettype wire

// File: rtl/mmc3_map.sv
// Address decode and bank mapping of one bus access.
`default_nettype none

module mmc3_map (
  input  mmc3_pkg::in_item_t   item_i,
  input  mmc3_pkg::map_state_t state_i,
  output logic [2:0]           region_o,
  output logic [18:0]          mapped_address_o
);
  import mmc3_pkg::*;

  logic [15:0]         addr;
  logic [2:0]          chr_slot;
  logic [2:0]          chr_sel;
  logic [2:0]          chr_idx;
  logic [7:0]          chr_raw;
  logic [7:0]          chr_last;
  logic [7:0]          chr_bank;
  logic [1:0]          prg_slot;
  logic [PrgMaskW-1:0] prg_last;
  logic [PrgMaskW-1:0] prg_second;
  logic [PrgMaskW-1:0] prg_bank;
  logic                in_chr, in_nt, in_wram, in_prg;

  assign addr     = item_i.address;
  assign chr_slot = addr[12:10];
  assign prg_slot = addr[14:13];

  // Pattern space: slots 0-3 use the 2 KB registers in pairs, 4-7 the 1 KB ones,
  // swapped as halves when the inversion bit is set.
  assign chr_sel  = chr_slot ^ {state_i.chr_invert, 2'b00};
  assign chr_idx  = chr_sel[2] ? (chr_sel - 3'd2) : {2'b00, chr_sel[1]};
  assign chr_raw  = state_i.bank_numbers[chr_idx];
  assign chr_last = state_i.chr_bank_mask;

  always_comb begin
    if (!state_i.mapping_live) begin
      chr_bank = ((chr_slot == 3'd0) || (chr_slot == 3'd3))
               ? ((chr_last - 8'd1) & chr_last) : chr_last;
    end else if (chr_sel[2]) begin
      chr_bank = chr_raw;
    end else begin
      chr_bank = {chr_raw[7:1], chr_sel[0]};
    end
    chr_bank = chr_bank & chr_last;
  end

  // Program space: the last window is fixed, the other fixed one swaps with
  // register 6 according to the program mode bit.
  assign prg_last   = state_i.prg_bank_mask;
  assign prg_second = (prg_last - 6'd1) & prg_last;

  always_comb begin
    if (prg_slot == 2'd3) begin
      prg_bank = prg_last;
    end else if (!state_i.mapping_live) begin
      prg_bank = (prg_slot == 2'd1) ? prg_last : prg_second;
    end else if (prg_slot == 2'd1) begin
      prg_bank = state_i.bank_numbers[7][PrgMaskW-1:0];
    end else if ((prg_slot == 2'd0) == !state_i.prg_mode) begin
      prg_bank = state_i.bank_numbers[6][PrgMaskW-1:0];
    end else begin
      prg_bank = prg_second;
    end
    prg_bank = prg_bank & prg_last;
  end

  assign in_chr  = (addr[15:13] == 3'b000);
  assign in_nt   = (addr[15:12] == 4'h2);
  assign in_wram = (addr[15:13] == 3'b011);
  assign in_prg  = addr[15];

  always_comb begin
    region_o         = REGION_NONE;
    mapped_address_o = '0;
    case (item_i.kind)
      KIND_READ: begin
        if (in_chr) begin
          region_o         = REGION_CHR;
          mapped_address_o = {1'b0, chr_bank, addr[9:0]};
        end else if (in_nt) begin
          region_o         = REGION_NT;
          mapped_address_o = {7'd0, addr[11:0]};
        end else if (in_wram) begin
          region_o         = REGION_WRAM;
          mapped_address_o = {6'd0, addr[12:0]};
        end else if (in_prg) begin
          region_o         = REGION_PRG;
          mapped_address_o = {prg_bank, addr[12:0]};
        end
      end
      KIND_WRITE: begin
        if (in_nt) begin
          region_o         = REGION_NT;
          mapped_address_o = {7'd0, addr[11:0]};
        end else if (in_wram) begin
          region_o         = REGION_WRAM;
          mapped_address_o = {6'd0, addr[12:0]};
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/mmc3_bank_mapper_irq.sv
// Top level of the cartridge bank mapper with scanline interrupt counter.
//
// Usage: each input beat on in_* is one bus event: a read, a write or a
// scanline tick. Every beat yields exactly one result beat on out_*, in
// order, giving the target region, the byte offset inside it, the current
// mirroring and whether a tick raised the interrupt. Writes at $8000 and
// above program the mapper registers; their result reports no region.
// The cfg_* channel sets the bank masks and four-screen wiring; it is
// always ready and should only be written while no beats are in flight.
// The beat is taken into the input register at the accepting edge, and the
// mapping and register update load the result register from it when that
// register is free or emptying. Throughput is one beat per cycle while the
// receiver keeps up, set by the single pass between those two registers.
// When the receiver stalls, the result register holds and the input
// register keeps one further beat, after which in_ready_o drops until
// out_ready_i returns. Reset empties both registers, restores the masks to
// their full values and returns to the power-on mapping that uses the last
// banks until a bank number is written.
`default_nettype none

module mmc3_bank_mapper_irq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mmc3_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mmc3_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [7:0]          cfg_data_i
);
  import mmc3_pkg::*;

  logic       in_valid_q;
  in_item_t   in_item_q;
  logic       out_valid_q;
  out_item_t  out_item_q;
  out_item_t  out_item_d;
  logic       advance;
  map_state_t map_state;
  logic [1:0] mirroring;
  logic       irq_fire;
  logic [2:0] region;
  logic [18:0] mapped_address;

  // The held beat moves on whenever the result register is free or emptying.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  mmc3_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (in_item_q),
    .advance_i   (advance),
    .state_o     (map_state),
    .mirroring_o (mirroring),
    .irq_fire_o  (irq_fire)
  );

  // Mapping sees the state as it stood before this beat's own write.
  mmc3_map u_map (
    .item_i           (in_item_q),
    .state_i          (map_state),
    .region_o         (region),
    .mapped_address_o (mapped_address)
  );

  assign out_item_d = '{region:         region,
                        mapped_address: mapped_address,
                        mirroring:      mirroring,
                        irq_fire:       irq_fire};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= in_data_i;
    end
    if (advance) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

endmodule

`default_nettype wire

// File: rtl/mmc3_checker.sv
// Port-level checker for the bank mapper and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module mmc3_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input mmc3_pkg::in_item_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input mmc3_pkg::out_item_t out_data_o,
  input logic                cfg_valid_i,
  input logic                cfg_ready_o,
  input logic [1:0]          cfg_index_i,
  input logic [7:0]          cfg_data_i
);
  import mmc3_pkg::*;

  logic unused_inputs;
  assign unused_inputs = in_valid_i ^ (^in_data_i) ^ cfg_valid_i ^ cfg_ready_o
                       ^ (^cfg_index_i) ^ (^cfg_data_i);

  // A stalled result beat stays offered and unchanged.
  `MMC3_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "result beat dropped while stalled")
  `MMC3_ASSERT(a_out_stable, out_valid_o && !out_ready_i |=> $stable(out_data_o), "stalled result beat changed")

  // Input is refused only while both pipeline registers are full and stalled.
  `MMC3_ASSERT(a_ready_stall, !in_ready_o |-> out_valid_o && !out_ready_i, "input refused without a stall")

  // An interrupt comes only from a tick, which maps to no region.
  `MMC3_ASSERT(a_irq_tick, out_valid_o && out_data_o.irq_fire |-> (out_data_o.region == REGION_NONE) && (out_data_o.mapped_address == '0), "interrupt on a bus access")

  // Once reset has been seen at an edge, no result is offered in the next cycle.
  `MMC3_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_o, "result valid after reset")

endmodule

bind mmc3_bank_mapper_irq mmc3_checker u_checker (.*);

`default_nettype wire

// File: verif/mmc3_bank_mapper_irq_test.sv
// Self-checking testbench for the cartridge bank mapper with scanline interrupt counter.
`timescale 1ns / 100ps

module mmc3_bank_mapper_irq_test;
  import mmc3_pkg::*;

  // The fourth kind code has no meaning; the block must answer it with no region.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Base addresses of the four mapper register pairs; address bit 0 picks the pair member.
  localparam logic [15:0] BANK_REG_BASE   = 16'h8000;
  localparam logic [15:0] MIRROR_REG_BASE = 16'hA000;
  localparam logic [15:0] IRQ_REG_BASE    = 16'hC000;
  localparam logic [15:0] ENABLE_REG_BASE = 16'hE000;

  localparam int unsigned LONG_HOLD   = 80;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned SETTLE      = 4;

  logic      clk = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready_o;
  in_item_t  in_beat = '0;
  logic      out_valid_o;
  logic      out_ready = 1'b0;
  out_item_t out_data_o;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready_o;
  logic [1:0] cfg_index = CFG_PRG_MASK;
  logic [7:0] cfg_data = 8'd0;

  mmc3_bank_mapper_irq dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_beat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #10 clk = ~clk;

  // Bus events waiting to be offered, and the results the mapper owes us, oldest first.
  in_item_t  bus_event_q[$];
  out_item_t mapped_result_q[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned queued_events = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned mismatch_count = 0;

  // ---------------------------------------------------------------------------
  // Mirror of the mapper: configuration copy and the register state that the
  // bus writes and scanline ticks move.
  // ---------------------------------------------------------------------------
  logic [5:0] prg_mask = 6'h3F;
  logic [7:0] chr_mask = 8'hFF;
  logic       four_scr = 1'b0;

  logic [2:0] sel_index = '0;
  logic       prg_swap = 1'b0;
  logic       chr_invert = 1'b0;
  logic [7:0] bank_regs [8] = '{default: 8'd0};
  logic       banks_live = 1'b0;
  logic       mirror_h = 1'b0;
  logic [7:0] irq_latch = '0;
  logic [7:0] scan_count = '0;
  logic       reload_req = 1'b0;
  logic       irq_enable = 1'b0;

  // Bank behind one of the eight 1 KB pattern windows. Until the first bank
  // number is written, windows 0 and 3 show the second-to-last bank and the
  // rest the last one. With inversion the 2 KB pair moves to the upper half.
  function automatic logic [7:0] chr_window_bank(input logic [2:0] slot);
    logic [2:0] s;
    logic [7:0] b;
    if (!banks_live) begin
      b = (slot == 3'd0 || slot == 3'd3) ? ((chr_mask - 8'd1) & chr_mask) : chr_mask;
    end else begin
      s = chr_invert ? (slot ^ 3'd4) : slot;
      if (s < 3'd4) begin
        // The 2 KB banks ignore their lowest bit; the window picks the half.
        b = (bank_regs[s >> 1] & 8'hFE) | {7'd0, s[0]};
      end else begin
        b = bank_regs[s - 3'd2];
      end
    end
    return b & chr_mask;
  endfunction

  // Bank behind one of the four 8 KB program windows. The top window is
  // always the last bank; the mode bit swaps the switchable and the fixed
  // second-to-last bank between the first and third windows.
  function automatic logic [5:0] prg_window_bank(input logic [1:0] slot);
    logic [5:0] second;
    logic [7:0] b;
    second = (prg_mask - 6'd1) & prg_mask;
    if (slot == 2'd3) begin
      b = {2'b00, prg_mask};
    end else if (!banks_live) begin
      b = (slot == 2'd1) ? {2'b00, prg_mask} : {2'b00, second};
    end else if (slot == 2'd1) begin
      b = bank_regs[7];
    end else if ((slot == 2'd0) == !prg_swap) begin
      b = bank_regs[6];
    end else begin
      b = {2'b00, second};
    end
    return b[5:0] & prg_mask;
  endfunction

  // Works out the result of one bus event and applies its side effects.
  function automatic out_item_t map_bus_event(input in_item_t ev);
    out_item_t r;
    logic [15:0] a;
    r = '0;
    a = ev.address;
    r.region = REGION_NONE;
    case (ev.kind)
      KIND_READ: begin
        if (a < 16'h2000) begin
          r.region = REGION_CHR;
          r.mapped_address = {1'b0, chr_window_bank(a[12:10]), a[9:0]};
        end else if (a < 16'h3000) begin
          r.region = REGION_NT;
          r.mapped_address = {7'd0, a[11:0]};
        end else if (a >= 16'h6000 && a < 16'h8000) begin
          r.region = REGION_WRAM;
          r.mapped_address = {6'd0, a[12:0]};
        end else if (a >= 16'h8000) begin
          r.region = REGION_PRG;
          r.mapped_address = {prg_window_bank(a[14:13]), a[12:0]};
        end
      end
      KIND_WRITE: begin
        if (a >= 16'h2000 && a < 16'h3000) begin
          r.region = REGION_NT;
          r.mapped_address = {7'd0, a[11:0]};
        end else if (a >= 16'h6000 && a < 16'h8000) begin
          r.region = REGION_WRAM;
          r.mapped_address = {6'd0, a[12:0]};
        end else if (a >= 16'h8000) begin
          // Register writes report no region.
          case (a[14:13])
            2'd0: begin
              if (a[0]) begin
                bank_regs[sel_index] = ev.write_data;
                banks_live = 1'b1;
              end else begin
                sel_index  = ev.write_data[2:0];
                prg_swap   = ev.write_data[6];
                chr_invert = ev.write_data[7];
              end
            end
            2'd1: begin
              // The odd register is RAM protect, which this mapper leaves out.
              if (!a[0]) begin
                mirror_h = ev.write_data[0];
              end
            end
            2'd2: begin
              if (a[0]) begin
                scan_count = 8'd0;
                reload_req = 1'b1;
              end else begin
                irq_latch = ev.write_data;
              end
            end
            default: begin
              irq_enable = a[0];
            end
          endcase
        end
      end
      KIND_TICK: begin
        if (scan_count == 8'd0 || reload_req) begin
          scan_count = irq_latch;
          reload_req = 1'b0;
        end else begin
          scan_count = scan_count - 8'd1;
          r.irq_fire = (scan_count == 8'd0) && irq_enable;
        end
      end
      default: begin
      end
    endcase
    r.mirroring = four_scr ? MIRROR_FOUR : (mirror_h ? MIRROR_HORIZONTAL : MIRROR_VERTICAL);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender. A beat stays on the bus until it is taken; the expectation is
  // worked out at the edge that accepts it, so the mirror advances in step
  // with the block.
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        mapped_result_q.push_back(map_bus_event(in_beat));
      end
      if (!in_valid || in_ready_o) begin
        if (bus_event_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_beat  <= bus_event_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver. Normally it stalls at random; on request it holds off for a long
  // stretch so that the block backs up and lowers in_ready_o.
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      out_ready   <= 1'b0;
      hold_left   <= LONG_HOLD;
      hold_served <= hold_served + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result checker: every accepted result beat is matched against the oldest
  // expectation, field by field.
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (mapped_result_q.size() == 0) begin
        if (mismatch_count < 10) begin
          $display("%0t: result beat with nothing expected: region %0d offset %h",
                   $time, out_data_o.region, out_data_o.mapped_address);
        end
        mismatch_count++;
      end else begin
        want = mapped_result_q.pop_front();
        if (out_data_o.region !== want.region ||
            out_data_o.mapped_address !== want.mapped_address ||
            out_data_o.mirroring !== want.mirroring ||
            out_data_o.irq_fire !== want.irq_fire) begin
          if (mismatch_count < 10) begin
            $display("%0t: mismatch, expected region %0d offset %h mirroring %0d irq %b",
                     $time, want.region, want.mapped_address, want.mirroring,
                     want.irq_fire);
            $display("%0t:           got      region %0d offset %h mirroring %0d irq %b",
                     $time, out_data_o.region, out_data_o.mapped_address,
                     out_data_o.mirroring, out_data_o.irq_fire);
          end
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: ends the run if no beat moves on any channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready) || (cfg_valid && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic push_event(input logic [1:0] kind, input logic [15:0] addr,
                            input logic [7:0] data);
    in_item_t ev;
    ev.kind       = kind;
    ev.address    = addr;
    ev.write_data = data;
    bus_event_q.push_back(ev);
    queued_events++;
  endtask

  // Random address inside one register's 8 KB range, with bit 0 chosen.
  function automatic logic [15:0] reg_addr(input logic [15:0] base, input logic odd);
    return ((base | 16'($urandom_range(0, 16'h1FFF))) & 16'hFFFE) | {15'd0, odd};
  endfunction

  // One short, mostly well-formed sequence of bus events with random content.
  task automatic queue_random_group();
    int unsigned pick;
    int unsigned n;
    logic [15:0] a;
    logic [1:0]  k;
    pick = $urandom_range(99);
    if (pick < 25) begin
      // Bank select followed by a bank number for that slot.
      push_event(KIND_WRITE, reg_addr(BANK_REG_BASE, 1'b0), 8'($urandom));
      push_event(KIND_WRITE, reg_addr(BANK_REG_BASE, 1'b1), 8'($urandom));
    end else if (pick < 50) begin
      n = $urandom_range(1, 4);
      repeat (n) begin
        case ($urandom_range(3))
          0: a = 16'($urandom_range(0, 16'h1FFF));
          1: a = 16'h8000 | 16'($urandom_range(0, 16'h7FFF));
          2: a = ($urandom_range(1) != 0) ? 16'h2000 | 16'($urandom_range(0, 16'h0FFF))
                                          : 16'h6000 | 16'($urandom_range(0, 16'h1FFF));
          default: a = 16'($urandom);
        endcase
        k = ($urandom_range(3) == 0 && a < 16'h8000) ? KIND_WRITE : KIND_READ;
        push_event(k, a, 8'($urandom));
      end
    end else if (pick < 58) begin
      push_event(KIND_WRITE, reg_addr(MIRROR_REG_BASE, 1'($urandom)), 8'($urandom));
    end else if (pick < 72) begin
      // Interrupt set-up: mostly short latches so the counter runs out often.
      push_event(KIND_WRITE, reg_addr(IRQ_REG_BASE, 1'b0),
                 ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6)));
      if ($urandom_range(1) != 0) begin
        push_event(KIND_WRITE, reg_addr(IRQ_REG_BASE, 1'b1), 8'($urandom));
      end
      push_event(KIND_WRITE, reg_addr(ENABLE_REG_BASE, $urandom_range(3) != 0),
                 8'($urandom));
    end else if (pick < 88) begin
      n = $urandom_range(1, ($urandom_range(3) == 0) ? 40 : 6);
      repeat (n) begin
        push_event(KIND_TICK, 16'($urandom), 8'($urandom));
      end
    end else begin
      push_event(2'($urandom), 16'($urandom), 8'($urandom));
    end
  endtask

  task automatic queue_random_events(input int unsigned count);
    int unsigned goal;
    @(negedge clk);
    goal = queued_events + count;
    while (queued_events < goal) begin
      queue_random_group();
    end
  endtask

  // Waits until every queued beat has been sent and answered, then lets the
  // pipeline settle before the configuration may be touched.
  task automatic wait_drained();
    do @(negedge clk);
    while (bus_event_q.size() != 0 || in_valid || mapped_result_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] index, input logic [7:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk);
    while (!(cfg_valid && cfg_ready_o));
    cfg_valid <= 1'b0;
    case (index)
      CFG_PRG_MASK:    prg_mask = value[5:0];
      CFG_CHR_MASK:    chr_mask = value;
      CFG_FOUR_SCREEN: four_scr = value[0];
      default: begin
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    send_idle_pct = 23;
    recv_idle_pct = 55;

    // Power-on mapping with full masks: pattern windows 0 and 7, the fixed
    // program windows, the start of each RAM range and both edges of the gap.
    push_event(KIND_READ, 16'h0000, 8'h00);
    push_event(KIND_READ, 16'h1FFF, 8'h00);
    push_event(KIND_READ, 16'h8000, 8'h00);
    push_event(KIND_READ, 16'hA000, 8'h00);
    push_event(KIND_READ, 16'hFFFF, 8'h00);
    push_event(KIND_READ, 16'h2000, 8'h00);
    push_event(KIND_READ, 16'h3000, 8'h00);
    push_event(KIND_READ, 16'h5FFF, 8'h00);
    push_event(KIND_READ, 16'h6000, 8'h00);
    // A write below the nametables gives no region; nametable and RAM writes map.
    push_event(KIND_WRITE, 16'h1FFF, 8'hFF);
    push_event(KIND_WRITE, 16'h2ABC, 8'h5A);
    push_event(KIND_WRITE, 16'h6123, 8'hA5);
    push_event(KIND_UNUSED, 16'hFFFF, 8'hFF);
    // Select slot 6 with both mode bits set, then go live with bank 255; the
    // mode bits must act on the very next reads.
    push_event(KIND_WRITE, 16'h8000, 8'hC6);
    push_event(KIND_WRITE, 16'h8001, 8'hFF);
    push_event(KIND_READ, 16'hC000, 8'h00);
    push_event(KIND_READ, 16'h1000, 8'h00);
    // Horizontal mirroring; the RAM protect register must change nothing.
    push_event(KIND_WRITE, 16'hA000, 8'h01);
    push_event(KIND_WRITE, 16'hA001, 8'h00);
    // Latch of one, reload, enable: ticks reload, fire, reload again.
    push_event(KIND_WRITE, 16'hC000, 8'h01);
    push_event(KIND_WRITE, 16'hC001, 8'h00);
    push_event(KIND_WRITE, 16'hE001, 8'h00);
    push_event(KIND_TICK, 16'h0000, 8'h00);
    push_event(KIND_TICK, 16'hFFFF, 8'hFF);
    push_event(KIND_TICK, 16'h0000, 8'h00);
    push_event(KIND_WRITE, 16'hE000, 8'h00);

    repeat (7) @(posedge clk);
    rst_ni <= 1'b1;

    queue_random_events(200);
    wait_drained();

    // Smallest cartridge, four-screen wiring; the sender also pauses once
    // until every result is back.
    write_cfg(CFG_PRG_MASK, 8'd1);
    write_cfg(CFG_CHR_MASK, 8'd1);
    write_cfg(CFG_FOUR_SCREEN, 8'd1);
    send_idle_pct = 55;
    recv_idle_pct = 23;
    queue_random_events(100);
    wait_drained();
    queue_random_events(100);
    wait_drained();

    // Largest cartridge, no idling, and one long receiver hold-off so the
    // block fills and stalls its input.
    write_cfg(CFG_PRG_MASK, 8'd63);
    write_cfg(CFG_CHR_MASK, 8'd255);
    write_cfg(CFG_FOUR_SCREEN, 8'd0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(negedge clk);
    hold_requests = hold_requests + 1;
    queue_random_events(200);
    wait_drained();

    // A random cartridge size.
    write_cfg(CFG_PRG_MASK, 8'((1 << $urandom_range(1, 6)) - 1));
    write_cfg(CFG_CHR_MASK, 8'((1 << $urandom_range(1, 8)) - 1));
    write_cfg(CFG_FOUR_SCREEN, 8'($urandom_range(1)));
    queue_random_events(200);
    wait_drained();

    if (mismatch_count == 0 && mapped_result_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: mmc3_bank_mapper_irq.f
+incdir+rtl
rtl/mmc3_pkg.sv
rtl/mmc3_regs.sv
rtl/mmc3_map.sv
rtl/mmc3_bank_mapper_irq.sv
rtl/mmc3_checker.sv
verif/mmc3_bank_mapper_irq_test.sv
